/* src/fse_pkg.sv */
// ----------------------------------------------------------------------------
// fse_pkg
// Shared types and constants for the FASTA symbol encoder: operation and
// result codes, register indexes, the command queue entry and the result.
// ----------------------------------------------------------------------------
package fse_pkg;

  // Input operations
  localparam logic [1:0] OP_DATA = 2'd0;
  localparam logic [1:0] OP_MAP  = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_SYMBOL = 3'd0;
  localparam logic [2:0] KIND_RANGE  = 3'd1;
  localparam logic [2:0] KIND_COUNT  = 3'd2;
  localparam logic [2:0] KIND_TOTALS = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  // Configuration register indexes
  localparam logic [7:0] CFG_NUM_CHARS      = 8'd0;
  localparam logic [7:0] CFG_SPECIAL_FROM   = 8'd1;
  localparam logic [7:0] CFG_SEPARATOR_CODE = 8'd2;
  localparam logic [7:0] CFG_UNDEFINED_CODE = 8'd3;

  // Configuration reset values
  localparam logic [5:0] NUM_CHARS_RST      = 6'd4;
  localparam logic [7:0] SPECIAL_FROM_RST   = 8'd254;
  localparam logic [7:0] SEPARATOR_CODE_RST = 8'd255;
  localparam logic [7:0] UNDEFINED_CODE_RST = 8'd253;

  // Characters with a meaning of their own
  localparam logic [7:0] ASCII_GT    = 8'h3E;
  localparam logic [7:0] ASCII_NL    = 8'h0A;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_TAB   = 8'h09;
  localparam logic [7:0] ASCII_CR    = 8'h0D;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [5:0] num_chars;
    logic [7:0] special_from;
    logic [7:0] separator_code;
    logic [7:0] undefined_code;
  } fse_cfg_t;

  // One classified item on its way to the back end
  typedef struct packed {
    logic       eoi;   // end of input
    logic [7:0] raw;   // raw byte
    logic [7:0] cc;    // mapped code
    logic       nl;    // byte is newline
    logic       gt;    // byte is '>'
    logic       ws;    // byte is whitespace
  } fse_cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] position;
    logic [7:0]  code;
    logic [31:0] amount;
    logic        final_res;
  } fse_res_t;

  // 32-bit increment that sticks at all ones
  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

/* src/fasta_symbol_encoder_unit.sv */
// ----------------------------------------------------------------------------
// fasta_symbol_encoder_unit
// FASTA byte stream encoder with loadable symbol map, run and count report.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one transaction per item:
//   operation 0 feeds a file byte, 1 loads symbol map entry in_byte with
//   map_value, 2 marks end of input. Map loads take effect for the very
//   next byte. Results leave on out_valid/out_ready; final_res flags the
//   last result of an item.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are
//   always taken and must only be issued while the block is idle.
// Timing:
//   A byte's first result passes the map read at the accepting edge, the
//   queue write and the output register. Steady state is one byte per
//   cycle while out_ready is high; a byte that closes a special run emits
//   its range, then its symbol, and end of input emits the open range,
//   min(num_chars, MAX_SYMBOLS) counts and the totals, one result per cycle.
//   A 4-entry command queue lets input flow while the receiver stalls;
//   once it plus the lookup stage hold 4, in_ready drops until results drain.
// Reset:
//   rst clears stream state, the error latch and configuration to defaults;
//   the symbol map holds garbage until loaded.
// ----------------------------------------------------------------------------
module fasta_symbol_encoder_unit import fse_pkg::*; #(
  parameter int MAX_SYMBOLS = 4,
  parameter int COUNT_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  in_byte,
  input  logic [7:0]  map_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [31:0] position,
  output logic [7:0]  code,
  output logic [31:0] amount,
  output logic        final_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  fse_cfg_t          cfg;
  fse_cmd_t          push_cmd;
  fse_cmd_t          head_cmd;
  fse_res_t          res;
  logic              push;
  logic              pop;
  logic              not_empty;
  logic [QCNT_W-1:0] q_count;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_chars      <= NUM_CHARS_RST;
      cfg.special_from   <= SPECIAL_FROM_RST;
      cfg.separator_code <= SEPARATOR_CODE_RST;
      cfg.undefined_code <= UNDEFINED_CODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NUM_CHARS:      cfg.num_chars      <= cfg_data[5:0];
        CFG_SPECIAL_FROM:   cfg.special_from   <= cfg_data;
        CFG_SEPARATOR_CODE: cfg.separator_code <= cfg_data;
        CFG_UNDEFINED_CODE: cfg.undefined_code <= cfg_data;
        default: ;
      endcase
    end
  end

  fse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .in_byte   (in_byte),
    .map_value (map_value),
    .q_count   (q_count),
    .push      (push),
    .cmd       (push_cmd)
  );

  fse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .head      (head_cmd),
    .not_empty (not_empty),
    .count     (q_count)
  );

  fse_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (head_cmd),
    .cmd_valid (not_empty),
    .cmd_pop   (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  // Result fields
  assign kind      = res.kind;
  assign position  = res.position;
  assign code      = res.code;
  assign amount    = res.amount;
  assign final_res = res.final_res;

endmodule

/* src/fse_front.sv */
// ----------------------------------------------------------------------------
// fse_front
// Input side: accepts items, owns the symbol map, looks up each data byte
// and classifies it before pushing a command into the queue.
// ----------------------------------------------------------------------------
module fse_front import fse_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        operation,
  input  logic [7:0]        in_byte,
  input  logic [7:0]        map_value,
  input  logic [QCNT_W-1:0] q_count,
  output logic              push,
  output fse_cmd_t          cmd
);

  logic [7:0] map_mem [256];
  logic [7:0] rd_code;
  logic       s1_valid;
  logic       s1_eoi;
  logic [7:0] s1_byte;
  logic       accept;

  // Credit check: room for the lookup stage and one more item
  assign in_ready = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_valid))
                    < (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  // Symbol map, registered read
  always_ff @(posedge clk) begin
    if (accept && operation == OP_MAP) begin
      map_mem[in_byte] <= map_value;
    end
    rd_code <= map_mem[in_byte];
  end

  // Lookup stage: data bytes and end of input only
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (operation == OP_DATA || operation == OP_END);
    end
    s1_eoi  <= (operation == OP_END);
    s1_byte <= in_byte;
  end

  // Classify the byte
  assign push    = s1_valid;
  assign cmd.eoi = s1_eoi;
  assign cmd.raw = s1_byte;
  assign cmd.cc  = rd_code;
  assign cmd.nl  = (s1_byte == ASCII_NL);
  assign cmd.gt  = (s1_byte == ASCII_GT);
  assign cmd.ws  = (s1_byte == ASCII_SPACE) ||
                   (s1_byte >= ASCII_TAB && s1_byte <= ASCII_CR);

endmodule

/* src/fse_queue.sv */
// ----------------------------------------------------------------------------
// fse_queue
// Small command FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module fse_queue import fse_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fse_cmd_t          push_data,
  input  logic              pop,
  output fse_cmd_t          head,
  output logic              not_empty,
  output logic [QCNT_W-1:0] count
);

  fse_cmd_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/fse_back.sv */
// ----------------------------------------------------------------------------
// fse_back
// Stream side: keeps line state, special runs, counts and positions, and
// sequences the results of each command into the output register.
// ----------------------------------------------------------------------------
module fse_back import fse_pkg::*; #(
  parameter int MAX_SYMBOLS = 4,
  parameter int COUNT_BITS  = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  fse_cfg_t cfg,
  input  fse_cmd_t cmd,
  input  logic     cmd_valid,
  output logic     cmd_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output fse_res_t res
);

  localparam int CntW  = (COUNT_BITS >= 32) ? 32 : COUNT_BITS;
  localparam int IdxW  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int IdxCW = $clog2(MAX_SYMBOLS + 1);
  localparam logic [CntW-1:0] CntMax = '1;

  typedef enum logic [1:0] {ST_RUN, ST_SYM, ST_CNT} state_t;

  state_t            state;
  logic [CntW-1:0]   counts [MAX_SYMBOLS];
  logic [CntW-1:0]   special_total;
  logic [31:0]       out_position;
  logic [31:0]       run_length;
  logic [31:0]       run_start;
  logic              header_seen;
  logic              at_line_start;
  logic              in_header;
  logic              failed;
  logic [IdxCW-1:0]  idx;
  logic [7:0]        hold_code;

  logic              ld;
  logic [IdxCW-1:0]  lim;
  logic [IdxW-1:0]   cnt_addr;
  logic [CntW-1:0]   cnt_rd;
  logic [CntW-1:0]   cnt_inc;
  logic [CntW-1:0]   spc_inc;
  logic [31:0]       pos_inc;
  logic [31:0]       run_inc;
  logic              code_undef;
  logic              code_special;
  logic              code_bad;

  // Output register can take a result
  assign ld      = !out_valid || out_ready;
  assign cmd_pop = (state == ST_RUN) && cmd_valid && ld;

  // Number of counts reported at end of input
  assign lim = ({1'b0, cfg.num_chars} < 7'(MAX_SYMBOLS)) ?
               IdxCW'(cfg.num_chars) : IdxCW'(MAX_SYMBOLS);

  // Count read port and saturating increments
  assign cnt_addr = (state == ST_CNT) ? idx[IdxW-1:0] : cmd.cc[IdxW-1:0];
  assign cnt_rd   = counts[cnt_addr];
  assign cnt_inc  = (cnt_rd == CntMax) ? cnt_rd : cnt_rd + 1'b1;
  assign spc_inc  = (special_total == CntMax) ? special_total : special_total + 1'b1;
  assign pos_inc  = sat_inc32(out_position);
  assign run_inc  = sat_inc32(run_length);

  // Code classification
  assign code_undef   = (cmd.cc == cfg.undefined_code);
  assign code_special = (cmd.cc >= cfg.special_from);
  assign code_bad     = ({1'b0, cmd.cc} >= {3'b0, cfg.num_chars}) ||
                        ({1'b0, cmd.cc} >= 9'(MAX_SYMBOLS));

  // Sequencer, stream state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RUN;
      out_valid     <= 1'b0;
      special_total <= '0;
      out_position  <= '0;
      run_length    <= '0;
      run_start     <= '0;
      header_seen   <= 1'b0;
      at_line_start <= 1'b1;
      in_header     <= 1'b0;
      failed        <= 1'b0;
      idx           <= '0;
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_RUN: begin
          if (cmd_pop && !failed) begin
            if (cmd.eoi) begin
              // close an open run, then walk the counts
              if (run_length != '0) begin
                res <= '{kind: KIND_RANGE, position: run_start, code: '0,
                         amount: run_length, final_res: 1'b0};
                out_valid <= 1'b1;
              end
              idx   <= '0;
              state <= ST_CNT;
            end else if (in_header) begin
              if (cmd.nl) begin
                in_header     <= 1'b0;
                at_line_start <= 1'b1;
              end
            end else if (at_line_start && cmd.gt) begin
              // header line; later headers insert a separator
              at_line_start <= 1'b0;
              in_header     <= 1'b1;
              header_seen   <= 1'b1;
              if (header_seen) begin
                if (run_length == '0) begin
                  run_start <= out_position;
                end
                run_length    <= run_inc;
                special_total <= spc_inc;
                res <= '{kind: KIND_SYMBOL, position: out_position,
                         code: cfg.separator_code, amount: '0, final_res: 1'b1};
                out_valid    <= 1'b1;
                out_position <= pos_inc;
              end
            end else if (cmd.ws) begin
              at_line_start <= cmd.nl;
            end else begin
              at_line_start <= 1'b0;
              if (code_undef || (!code_special && code_bad)) begin
                failed <= 1'b1;
                res <= '{kind: KIND_ERROR, position: out_position, code: cmd.raw,
                         amount: '0, final_res: 1'b1};
                out_valid <= 1'b1;
              end else if (code_special) begin
                if (run_length == '0) begin
                  run_start <= out_position;
                end
                run_length    <= run_inc;
                special_total <= spc_inc;
                res <= '{kind: KIND_SYMBOL, position: out_position, code: cmd.cc,
                         amount: '0, final_res: 1'b1};
                out_valid    <= 1'b1;
                out_position <= pos_inc;
              end else begin
                counts[cnt_addr] <= cnt_inc;
                if (run_length != '0) begin
                  // ordinary symbol closes the run; symbol follows next
                  res <= '{kind: KIND_RANGE, position: run_start, code: '0,
                           amount: run_length, final_res: 1'b0};
                  out_valid  <= 1'b1;
                  run_length <= '0;
                  hold_code  <= cmd.cc;
                  state      <= ST_SYM;
                end else begin
                  res <= '{kind: KIND_SYMBOL, position: out_position, code: cmd.cc,
                           amount: '0, final_res: 1'b1};
                  out_valid    <= 1'b1;
                  out_position <= pos_inc;
                end
              end
            end
          end
        end
        ST_SYM: begin
          if (ld) begin
            res <= '{kind: KIND_SYMBOL, position: out_position, code: hold_code,
                     amount: '0, final_res: 1'b1};
            out_valid    <= 1'b1;
            out_position <= pos_inc;
            state        <= ST_RUN;
          end
        end
        ST_CNT: begin
          if (ld) begin
            if (idx < lim) begin
              res <= '{kind: KIND_COUNT, position: '0, code: 8'(idx),
                       amount: 32'(cnt_rd), final_res: 1'b0};
              out_valid <= 1'b1;
              idx       <= idx + 1'b1;
            end else begin
              // totals, then back to a clean stream
              res <= '{kind: KIND_TOTALS, position: out_position, code: '0,
                       amount: 32'(special_total), final_res: 1'b1};
              out_valid     <= 1'b1;
              special_total <= '0;
              out_position  <= '0;
              run_length    <= '0;
              run_start     <= '0;
              header_seen   <= 1'b0;
              at_line_start <= 1'b1;
              in_header     <= 1'b0;
              for (int i = 0; i < MAX_SYMBOLS; i++) begin
                counts[i] <= '0;
              end
              state <= ST_RUN;
            end
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

endmodule
